FILE: design/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// shared types and constants of the charging slot allocator
// ----------------------------------------------------------------------------
package csa_pkg;

	// fixed field widths of the item and result transfers
	localparam int ROBOT_ID_W = 8;
	localparam int GRANTED_W  = 3;
	localparam int WAITING_W  = 5;

	// number of distinct values on the robot_id field
	localparam int ID_SPACE = 256;

	// item command codes
	localparam logic CMD_VISIT = 1'b0;
	localparam logic CMD_FILL  = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_VISIT = 3'b010,
		ST_FILL  = 3'b100
	} csa_state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic accept;     // item transfer this cycle, latch payload
		logic visit_go;   // execute the latched visit and load the result
		logic fill_step;  // process one slot of the end-of-step fill
	} csa_ctrl_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic fill_last;  // slot walk stands on the last slot
		logic out_free;   // result register can take a new result
	} csa_stat_t;

endpackage

FILE: design/csa_if.sv
// ----------------------------------------------------------------------------
// csa_in_if / csa_out_if
// valid/ready channels for items and results of the slot allocator
// ----------------------------------------------------------------------------
interface csa_in_if;
	import csa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [ROBOT_ID_W-1:0] robot_id;
	logic                  carrying;
	logic                  request;
	logic                  done_req;

	modport source (
		output valid, cmd, robot_id, carrying, request, done_req,
		input  ready
	);
	modport sink (
		input  valid, cmd, robot_id, carrying, request, done_req,
		output ready
	);
endinterface

interface csa_out_if;
	import csa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 holds_slot;
	logic [GRANTED_W-1:0] granted;
	logic [WAITING_W-1:0] waiting;
	logic                 overflow;

	modport source (
		output valid, holds_slot, granted, waiting, overflow,
		input  ready
	);
	modport sink (
		input  valid, holds_slot, granted, waiting, overflow,
		output ready
	);
endinterface

FILE: design/charging_slot_allocator.sv
// ----------------------------------------------------------------------------
// charging_slot_allocator
// hands out charging slots to requesters through a fifo waiting list
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  item      in         valid/ready    cmd, robot_id, carrying, request, done_req
//  result    out        valid/ready    holds_slot, granted, waiting, overflow
//
//  a visit is a transfer in, then enqueue / ownership check / release
//  an end-of-step fill walks the slots one a cycle, the last only once the result
//  register has room, paced by the single read port of the waiting-queue ram
//  one item is in work at a time; the result register lets the next item
//  transfer in while the previous result still waits on result.ready
//  a full result register stalls the final step of an item until it drains
//  arst_n clears all slots and empties the queue; no clearing pass is needed
//
module charging_slot_allocator #(
	parameter int SLOTS       = 5,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_COUNT    = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	csa_in_if.sink     item,
	csa_out_if.source  result
);
	import csa_pkg::*;

	// command and status between sequencer and datapath
	csa_ctrl_t ctrl;
	csa_stat_t stat;

	// sequencer: idle -> visit or slot walk -> idle
	csa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_cmd   (item.cmd),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (item.ready)
	);

	// datapath: queue ram, slot table, result register
	csa_dp #(
		.SLOTS       (SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_COUNT    (ID_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.in_robot_id    (item.robot_id),
		.in_carrying    (item.carrying),
		.in_request     (item.request),
		.in_done_req    (item.done_req),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_holds_slot (result.holds_slot),
		.out_granted    (result.granted),
		.out_waiting    (result.waiting),
		.out_overflow   (result.overflow)
	);
endmodule

FILE: design/csa_ram.sv
// ----------------------------------------------------------------------------
// csa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module csa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/csa_ctrl.sv
// ----------------------------------------------------------------------------
// csa_ctrl
// sequencer of the slot allocator: accepts items, runs visit or slot walk
// ----------------------------------------------------------------------------
module csa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	input  csa_pkg::csa_stat_t stat,
	output csa_pkg::csa_ctrl_t ctrl,
	output logic               in_ready
);
	import csa_pkg::*;

	csa_state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		ctrl.accept    = 1'b0;
		ctrl.visit_go  = 1'b0;
		ctrl.fill_step = 1'b0;
		in_ready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctrl.accept = in_valid;
				if (in_valid) begin
					state_d = (in_cmd == CMD_FILL) ? ST_FILL : ST_VISIT;
				end
			end
			ST_VISIT: begin
				ctrl.visit_go = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				// last slot commits together with the result load
				ctrl.fill_step = !stat.fill_last || stat.out_free;
				if (stat.fill_last && stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> !in_ready)
		else $error("sequencer stayed ready after a transfer");

	a_visit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.visit_go |-> stat.out_free)
		else $error("visit executed while result register full");

	a_last_fill_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.fill_step && stat.fill_last && !stat.out_free))
		else $error("last fill step committed while result register full");
endmodule

FILE: design/csa_dp.sv
// ----------------------------------------------------------------------------
// csa_dp
// datapath: waiting queue, slot table, slot walk counter and result register
// ----------------------------------------------------------------------------
module csa_dp #(
	parameter int SLOTS       = 5,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_COUNT    = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  csa_pkg::csa_ctrl_t              ctrl,
	output csa_pkg::csa_stat_t              stat,
	input  logic [csa_pkg::ROBOT_ID_W-1:0]  in_robot_id,
	input  logic                            in_carrying,
	input  logic                            in_request,
	input  logic                            in_done_req,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_holds_slot,
	output logic [csa_pkg::GRANTED_W-1:0]   out_granted,
	output logic [csa_pkg::WAITING_W-1:0]   out_waiting,
	output logic                            out_overflow
);
	import csa_pkg::*;

	localparam int IdRange = (ID_COUNT < ID_SPACE) ? ID_COUNT : ID_SPACE;
	localparam int IdW     = $clog2(IdRange);
	localparam int QW      = $clog2(QUEUE_DEPTH);
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int SIW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int GW      = $clog2(SLOTS + 1);

	// id folding table, robot_id modulo the id count
	logic [IdW-1:0] id_map [ID_SPACE];
	for (genvar g = 0; g < ID_SPACE; g++) begin : g_id_map
		assign id_map[g] = IdW'(g % IdRange);
	end

	// latched item
	logic [IdW-1:0] id_q;
	logic           carry_q, req_q, done_q;

	// slot table
	logic           busy_q  [SLOTS];
	logic [IdW-1:0] owner_q [SLOTS];
	logic [SLOTS-1:0] match;

	// queue control
	logic [QW-1:0] head_q, tail_q, head_d;
	logic [CW-1:0] count_q, count_d;

	logic [SIW-1:0] slot_q;
	logic [GW-1:0]  gcnt_q, gcnt_d;

	logic           act, enq, ovf, grant, load;
	logic [IdW-1:0] ram_rdata;

	// result register
	logic                 out_valid_q;
	logic                 holds_q, ovf_q;
	logic [GRANTED_W-1:0] granted_q;
	logic [WAITING_W-1:0] waiting_q;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			match[s] = busy_q[s] && (owner_q[s] == id_q);
		end
	end

	assign act   = ctrl.visit_go && !carry_q;
	assign enq   = act && req_q && (count_q < CW'(QUEUE_DEPTH));
	assign ovf   = act && req_q && !(count_q < CW'(QUEUE_DEPTH));
	assign grant = ctrl.fill_step && !busy_q[slot_q] && (count_q != '0);
	assign load  = ctrl.visit_go || (ctrl.fill_step && stat.fill_last);

	assign stat.fill_last = (slot_q == SIW'(SLOTS - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	always_comb begin
		count_d = count_q;
		if (enq) begin
			count_d = count_q + 1'b1;
		end else if (grant) begin
			count_d = count_q - 1'b1;
		end
	end

	// head advances on every grant; the ram reads ahead at the next head
	always_comb begin
		head_d = head_q;
		if (grant) begin
			head_d = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		end
	end

	assign gcnt_d = gcnt_q + GW'(grant);

	csa_ram #(
		.WIDTH (IdW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (enq),
		.waddr (tail_q),
		.wdata (id_q),
		.raddr (head_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			id_q    <= id_map[in_robot_id];
			carry_q <= in_carrying;
			req_q   <= in_request;
			done_q  <= in_done_req;
		end
		if (grant) begin
			owner_q[slot_q] <= ram_rdata;
		end
		if (load) begin
			holds_q   <= act && (|match);
			ovf_q     <= ovf;
			granted_q <= ctrl.visit_go ? '0 : GRANTED_W'(gcnt_d);
			waiting_q <= WAITING_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				busy_q[s] <= 1'b0;
			end
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			gcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (grant && (slot_q == SIW'(s))) begin
					busy_q[s] <= 1'b1;
				end else if (act && done_q && match[s]) begin
					busy_q[s] <= 1'b0;
				end
			end
			head_q  <= head_d;
			count_q <= count_d;
			if (enq) begin
				tail_q <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ctrl.accept) begin
				slot_q <= '0;
				gcnt_q <= '0;
			end else if (ctrl.fill_step) begin
				gcnt_q <= gcnt_d;
				if (!stat.fill_last) begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_holds_slot = holds_q;
	assign out_granted    = granted_q;
	assign out_waiting    = waiting_q;
	assign out_overflow   = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_carry_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.visit_go && carry_q) |=> (count_q == $past(count_q)))
		else $error("carrying visit changed the queue");

	a_grant_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		grant |=> busy_q[$past(slot_q)])
		else $error("granted slot not marked busy");
endmodule

FILE: dv/csa_checker.sv
// ----------------------------------------------------------------------------
// csa_checker
// watches the item and result channels, tracks the slots and the waiting list,
// and compares every result transfer with the outcome worked out for its item
// ----------------------------------------------------------------------------
module csa_checker #(
	parameter int SLOTS       = 5,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_COUNT    = 256
) (
	input  logic clk,
	input  logic arst_n,
	csa_in_if    item_mon,
	csa_out_if   result_mon,
	output int   fail_count,
	output int   outstanding,
	output int   results_seen,
	output int   overflows_seen,
	output int   slots_granted,
	output int   owner_hits
);
	timeunit 1ns;
	timeprecision 1ps;
	import csa_pkg::*;

	typedef struct packed {
		logic                 holds_slot;
		logic [GRANTED_W-1:0] granted;
		logic [WAITING_W-1:0] waiting;
		logic                 overflow;
	} alloc_outcome_t;

	logic [ROBOT_ID_W-1:0] bay_owner [SLOTS];
	logic                  bay_taken [SLOTS];
	logic [ROBOT_ID_W-1:0] waitlist [$];
	alloc_outcome_t        pending_outcomes [$];

	// one item against the tracked slots and waiting list
	function automatic alloc_outcome_t predict_allocation(
		logic cmd, logic [ROBOT_ID_W-1:0] rid, logic carrying, logic request,
		logic done_req);
		alloc_outcome_t        o;
		logic [ROBOT_ID_W-1:0] id;
		int                    granted_n;
		o         = '0;
		granted_n = 0;
		id        = ROBOT_ID_W'(int'(rid) % ID_COUNT);
		if (cmd == CMD_VISIT) begin
			if (!carrying) begin
				if (request) begin
					if (waitlist.size() < QUEUE_DEPTH)
						waitlist.insert(waitlist.size(), id);
					else
						o.overflow = 1'b1;
				end
				// ownership is judged before any release
				for (int s = 0; s < SLOTS; s++)
					if (bay_taken[s] && bay_owner[s] == id)
						o.holds_slot = 1'b1;
				if (done_req)
					for (int s = 0; s < SLOTS; s++)
						if (bay_taken[s] && bay_owner[s] == id)
							bay_taken[s] = 1'b0;
			end
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (!bay_taken[s] && waitlist.size() > 0) begin
					bay_owner[s] = waitlist.pop_front();
					bay_taken[s] = 1'b1;
					granted_n++;
				end
			end
		end
		o.granted = GRANTED_W'(granted_n);
		o.waiting = WAITING_W'(waitlist.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_outcome_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				bay_taken[s] = 1'b0;
			waitlist.delete();
			pending_outcomes.delete();
			fail_count     = 0;
			results_seen   = 0;
			overflows_seen = 0;
			slots_granted  = 0;
			owner_hits     = 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				results_seen++;
				if (pending_outcomes.size() == 0) begin
					$error("unexpected result: holds_slot=%0d granted=%0d waiting=%0d overflow=%0d",
						result_mon.holds_slot, result_mon.granted, result_mon.waiting,
						result_mon.overflow);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (result_mon.holds_slot !== want.holds_slot) begin
						$error("holds_slot: expected %0d, got %0d", want.holds_slot,
							result_mon.holds_slot);
						fail_count++;
					end
					if (result_mon.granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted,
							result_mon.granted);
						fail_count++;
					end
					if (result_mon.waiting !== want.waiting) begin
						$error("waiting: expected %0d, got %0d", want.waiting,
							result_mon.waiting);
						fail_count++;
					end
					if (result_mon.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow,
							result_mon.overflow);
						fail_count++;
					end
					overflows_seen += want.overflow;
					slots_granted  += want.granted;
					owner_hits     += want.holds_slot;
				end
			end
			if (item_mon.valid && item_mon.ready)
				pending_outcomes.insert(pending_outcomes.size(),
					predict_allocation(item_mon.cmd, item_mon.robot_id,
					item_mon.carrying, item_mon.request, item_mon.done_req));
		end
		outstanding = pending_outcomes.size();
	end

endmodule

FILE: dv/tb_charging_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_charging_slot_allocator
// drives visits and end-of-step fills into the slot allocator under several
// flow-control regimes; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_charging_slot_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import csa_pkg::*;

	// generous watchdog for ~1300 items
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 300;
	// quiet time after the last settle, longer than a fill's slot walk
	localparam int DRAIN_CYCLES    = 20;
	// long receiver hold-off, enough to back the block up into its input
	localparam int HOLD_OFF_CYCLES = 80;

	typedef struct packed {
		logic                  cmd;
		logic [ROBOT_ID_W-1:0] robot_id;
		logic                  carrying;
		logic                  request;
		logic                  done_req;
	} charge_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	csa_in_if  item_ch ();
	csa_out_if result_ch ();

	int fails;
	int outstanding;
	int results_seen;
	int overflows_seen;
	int slots_granted;
	int owner_hits;

	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// bumped by the stimulus to ask the receiver for one long hold-off
	int hold_token     = 0;
	// item transfer seen at the last rising edge, read back at the falling edge
	logic item_fire_q  = 1'b0;

	// small set of recurring ids so that owners come back and release
	logic [ROBOT_ID_W-1:0] id_pool [8];

	charging_slot_allocator u_top (
		.clk,
		.arst_n,
		.item   (item_ch),
		.result (result_ch)
	);

	csa_checker u_checker (
		.clk,
		.arst_n,
		.item_mon       (item_ch),
		.result_mon     (result_ch),
		.fail_count     (fails),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.overflows_seen (overflows_seen),
		.slots_granted  (slots_granted),
		.owner_hits     (owner_hits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		item_fire_q <= item_ch.valid && item_ch.ready;

	// watchdog: a run that outlives the limit is broken
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stalls per phase, plus one long hold-off per request
	initial begin
		int hold_seen;
		int stall_left;
		hold_seen       = 0;
		stall_left      = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_token != hold_seen) begin
				hold_seen  = hold_token;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic charge_item_t visit(logic [ROBOT_ID_W-1:0] id, logic carrying,
		logic request, logic done_req);
		charge_item_t it;
		it.cmd      = CMD_VISIT;
		it.robot_id = id;
		it.carrying = carrying;
		it.request  = request;
		it.done_req = done_req;
		return it;
	endfunction

	// end of step; the other fields are don't-care, so they get random junk
	function automatic charge_item_t fill_step();
		charge_item_t it;
		it          = charge_item_t'($urandom);
		it.cmd      = CMD_FILL;
		return it;
	endfunction

	// mostly visits by known ids, now and then a stranger or a fill
	function automatic charge_item_t random_item();
		charge_item_t it;
		it.cmd      = ($urandom_range(99) < 20) ? CMD_FILL : CMD_VISIT;
		it.robot_id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(7)]
			: ROBOT_ID_W'($urandom);
		it.carrying = ($urandom_range(99) < 10);
		it.request  = ($urandom_range(99) < 50);
		it.done_req = ($urandom_range(99) < 35);
		return it;
	endfunction

	// entered and left at a falling edge; valid stays up after the transfer so
	// back-to-back items need no second assignment in the same step
	task automatic offer(input charge_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.cmd      <= it.cmd;
		item_ch.robot_id <= it.robot_id;
		item_ch.carrying <= it.carrying;
		item_ch.request  <= it.request;
		item_ch.done_req <= it.done_req;
		do @(negedge clk); while (!item_fire_q);
	endtask

	// stop offering and let every outstanding result come back
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// random traffic with occasional request floods that can overrun the queue
	task automatic run_traffic(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 4) begin
				burst = $urandom_range(20, 14);
				repeat (burst)
					offer(visit(id_pool[$urandom_range(7)], 1'b0, 1'b1,
						1'($urandom_range(1))));
				sent += burst;
			end else begin
				offer(random_item());
				sent++;
			end
		end
	endtask

	// receiver holds off for a long stretch while the sender keeps pushing
	task automatic back_pressure();
		hold_token <= hold_token + 1;
		run_traffic(16);
		settle();
	endtask

	initial begin
		item_ch.valid    = 1'b0;
		item_ch.cmd      = CMD_VISIT;
		item_ch.robot_id = '0;
		item_ch.carrying = 1'b0;
		item_ch.request  = 1'b0;
		item_ch.done_req = 1'b0;

		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			id_pool[i] = ROBOT_ID_W'($urandom);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty fill, extreme ids, carrying visits, ownership checks,
		// release of several slots owned by one id, ignored fields on a fill
		offer(fill_step());                       // nothing waiting, no grant
		offer(visit('0, 1'b0, 1'b1, 1'b0));
		offer(visit('1, 1'b0, 1'b1, 1'b0));
		offer(visit(8'h5a, 1'b0, 1'b1, 1'b1));    // release while owning nothing
		offer(visit(8'ha5, 1'b1, 1'b1, 1'b1));    // carrying: nothing happens
		offer(visit('0, 1'b0, 1'b0, 1'b0));       // waiting, not yet owning
		offer(fill_step());                       // three grants
		offer(visit('0, 1'b0, 1'b0, 1'b0));       // owner
		offer(visit('1, 1'b0, 1'b0, 1'b1));       // owner releases
		offer(visit('1, 1'b0, 1'b0, 1'b0));       // no longer an owner
		repeat (3)
			offer(visit(8'h07, 1'b0, 1'b1, 1'b0)); // same id queued three times
		offer(visit('0, 1'b1, 1'b0, 1'b1));       // carrying owner keeps its slot
		offer(fill_step());                       // id 7 takes three slots
		offer(visit(8'h07, 1'b0, 1'b1, 1'b1));    // queues again, frees all three
		offer(fill_step());
		offer(fill_step());                       // queue empty again
		offer('1);                                // fill with every other bit set
		offer(visit(8'h3c, 1'b0, 1'b1, 1'b1));
		offer(visit(8'hc3, 1'b0, 1'b0, 1'b1));
		settle();

		// phase: no idling, with one long hold-off on the result side
		back_pressure();
		run_traffic(ITEMS_PER_PHASE - 16);
		settle();

		// phase: sender mostly idle
		send_idle_pct  <= 74;
		recv_stall_pct <= 0;
		run_traffic(ITEMS_PER_PHASE);
		settle();

		// phase: receiver mostly stalling
		send_idle_pct  <= 0;
		recv_stall_pct <= 74;
		run_traffic(ITEMS_PER_PHASE);
		settle();

		// phase: light idling on both sides, another hold-off in the middle
		send_idle_pct  <= 12;
		recv_stall_pct <= 12;
		run_traffic(ITEMS_PER_PHASE / 2);
		back_pressure();
		run_traffic(ITEMS_PER_PHASE / 2);

		// drain, then a few quiet cycles to catch stray results
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d results: %0d slots granted, %0d owner visits, %0d dropped requests",
			results_seen, slots_granted, owner_hits, overflows_seen);
		if (fails == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
